>>> design/l2_learning_switch_decision_macros.svh
// Assertion helpers shared by the decision block.
`ifndef L2_LEARNING_SWITCH_DECISION_MACROS_SVH
`define L2_LEARNING_SWITCH_DECISION_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define L2SD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define L2SD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/l2sd_pkg.sv
`timescale 1ns / 1ps

package l2sd_pkg;

  localparam int MAC_W     = 48;
  localparam int PORT_W    = 8;
  localparam int SW_W      = 4;
  localparam int VID_W     = 12;
  localparam int VKEY_W    = 13;
  localparam int MCAST_BIT = 40;

  localparam logic [VKEY_W-1:0] UNTAGGED_KEY = 13'h1000;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MAC_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MAC_B = 1'b1;

  localparam logic [MAC_W-1:0] BLOCK_MAC_A_RST = 48'h0180C2000000;
  localparam logic [MAC_W-1:0] BLOCK_MAC_B_RST = 48'h01005E0000FB;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    ACT_BAD_SRC   = 3'd0,
    ACT_BLOCK     = 3'd1,
    ACT_FLOOD     = 3'd2,
    ACT_SAME_PORT = 3'd3,
    ACT_FORWARD   = 3'd4,
    ACT_FLUSHED   = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    JOB_DONE,
    JOB_PACKET,
    JOB_FLUSH
  } job_kind_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SCAN,
    BK_DECIDE,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic              command;
    logic [SW_W-1:0]   switch_id;
    logic [PORT_W-1:0] in_port;
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic              vlan_tagged;
    logic [VID_W-1:0]  vlan_id;
  } in_req_t;

  typedef struct packed {
    action_e           action;
    logic [PORT_W-1:0] egress_port;
    logic              learned;
    logic              table_full;
  } out_res_t;

  typedef struct packed {
    logic [SW_W-1:0]   sw;
    logic [VKEY_W-1:0] vkey;
  } tag_t;

  typedef struct packed {
    logic              valid;
    tag_t              tag;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
  } entry_t;

  typedef struct packed {
    job_kind_e         kind;
    action_e           action;
    tag_t              tag;
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  src;
    logic [MAC_W-1:0]  dst;
    logic              dst_mcast;
  } job_t;

  // Backpressure seen by the front end.
  typedef struct packed {
    logic q_full;
    logic clearing;
  } front_stat_t;

endpackage

>>> design/l2sd_front.sv
`timescale 1ns / 1ps

module l2sd_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [l2sd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [l2sd_pkg::MAC_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  l2sd_pkg::in_req_t                  in_req_i,
  input  l2sd_pkg::front_stat_t              stat_i,
  output logic                               push_o,
  output l2sd_pkg::job_t                     job_o
);

  logic [l2sd_pkg::MAC_W-1:0] block_a_q, block_a_d;
  logic [l2sd_pkg::MAC_W-1:0] block_b_q, block_b_d;

  always_comb begin
    block_a_d = block_a_q;
    block_b_d = block_b_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        l2sd_pkg::CFG_BLOCK_MAC_A: block_a_d = cfg_data_i;
        l2sd_pkg::CFG_BLOCK_MAC_B: block_b_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_a_q <= l2sd_pkg::BLOCK_MAC_A_RST;
      block_b_q <= l2sd_pkg::BLOCK_MAC_B_RST;
    end else begin
      block_a_q <= block_a_d;
      block_b_q <= block_b_d;
    end
  end

  assign in_ready_o = !stat_i.q_full && !stat_i.clearing;
  assign push_o     = in_valid_i && in_ready_o;

  // Classify: everything decidable without the table resolves here.
  always_comb begin
    job_o.action    = l2sd_pkg::ACT_FLOOD;
    job_o.tag.sw    = in_req_i.switch_id;
    job_o.tag.vkey  = in_req_i.vlan_tagged ? {1'b0, in_req_i.vlan_id}
                                           : l2sd_pkg::UNTAGGED_KEY;
    job_o.port      = in_req_i.in_port;
    job_o.src       = in_req_i.src_mac;
    job_o.dst       = in_req_i.dst_mac;
    job_o.dst_mcast = in_req_i.dst_mac[l2sd_pkg::MCAST_BIT];
    if (in_req_i.command) begin
      job_o.kind = l2sd_pkg::JOB_FLUSH;
    end else if (in_req_i.src_mac[l2sd_pkg::MCAST_BIT]) begin
      job_o.kind   = l2sd_pkg::JOB_DONE;
      job_o.action = l2sd_pkg::ACT_BAD_SRC;
    end else if (in_req_i.dst_mac == block_a_q || in_req_i.dst_mac == block_b_q) begin
      job_o.kind   = l2sd_pkg::JOB_DONE;
      job_o.action = l2sd_pkg::ACT_BLOCK;
    end else begin
      job_o.kind = l2sd_pkg::JOB_PACKET;
    end
  end

endmodule

>>> design/l2sd_queue.sv
`timescale 1ns / 1ps

module l2sd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  l2sd_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output l2sd_pkg::job_t job_o
);

  l2sd_pkg::job_t slot_q [l2sd_pkg::QUEUE_DEPTH];

  logic [l2sd_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [l2sd_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [l2sd_pkg::QPTR_W:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (l2sd_pkg::QPTR_W + 1)'(l2sd_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign job_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + l2sd_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + l2sd_pkg::QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (l2sd_pkg::QPTR_W + 1)'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - (l2sd_pkg::QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

>>> design/l2sd_back.sv
`timescale 1ns / 1ps
`include "l2_learning_switch_decision_macros.svh"

module l2sd_back #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  l2sd_pkg::job_t     q_job_i,
  output logic               q_pop_o,
  output logic               clearing_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output l2sd_pkg::out_res_t out_res_o
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [IW:0]   SCAN_END = (IW + 1)'(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  l2sd_pkg::entry_t mem_q [TABLE_DEPTH];
  l2sd_pkg::entry_t rd_data_q;

  l2sd_pkg::back_state_e state_q, state_d;

  logic [IW:0]   scan_q, scan_d;
  logic          chk_vld_q, chk_vld_d;
  logic [IW-1:0] chk_idx_q, chk_idx_d;
  logic          out_valid_q, out_valid_d;
  logic          dst_hit_q, dst_hit_d;
  logic          src_hit_q, src_hit_d;
  logic          free_hit_q, free_hit_d;
  logic [l2sd_pkg::PORT_W-1:0] dst_port_q, dst_port_d;
  logic [IW-1:0] src_idx_q, src_idx_d;
  logic [IW-1:0] free_idx_q, free_idx_d;

  l2sd_pkg::job_t     job_q, job_d;
  l2sd_pkg::out_res_t res_q, res_d;
  l2sd_pkg::out_res_t out_res_q;

  logic             q_pop;
  logic             mem_re;
  logic [IW-1:0]    mem_raddr;
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  l2sd_pkg::entry_t mem_wdata;
  logic             out_load;

  logic tag_eq, dst_m, src_m, free_m, flush_m, scan_done;

  // Compare of the entry read in the previous cycle against the current job.
  assign tag_eq  = rd_data_q.valid && rd_data_q.tag == job_q.tag;
  assign dst_m   = chk_vld_q && tag_eq && !job_q.dst_mcast && rd_data_q.mac == job_q.dst;
  assign src_m   = chk_vld_q && tag_eq && rd_data_q.mac == job_q.src;
  assign free_m  = chk_vld_q && !rd_data_q.valid;
  assign flush_m = chk_vld_q && rd_data_q.valid && rd_data_q.tag.sw == job_q.tag.sw;

  // Last read issued and its compare retired.
  assign scan_done = scan_q == SCAN_END && !chk_vld_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      l2sd_pkg::BK_CLEAR: begin
        if (scan_q[IW-1:0] == LAST_IDX) state_d = l2sd_pkg::BK_IDLE;
      end
      l2sd_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          state_d = (q_job_i.kind == l2sd_pkg::JOB_DONE) ? l2sd_pkg::BK_EMIT
                                                        : l2sd_pkg::BK_SCAN;
        end
      end
      l2sd_pkg::BK_SCAN: begin
        if (scan_done) begin
          state_d = (job_q.kind == l2sd_pkg::JOB_FLUSH) ? l2sd_pkg::BK_EMIT
                                                       : l2sd_pkg::BK_DECIDE;
        end
      end
      l2sd_pkg::BK_DECIDE: state_d = l2sd_pkg::BK_EMIT;
      l2sd_pkg::BK_EMIT: begin
        if (!out_valid_q || out_ready_i) state_d = l2sd_pkg::BK_IDLE;
      end
      default: state_d = l2sd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = scan_q[IW-1:0];
    mem_we     = 1'b0;
    mem_waddr  = chk_idx_q;
    mem_wdata  = rd_data_q;
    mem_wdata.valid = 1'b0;
    out_load   = 1'b0;
    scan_d     = scan_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = scan_q[IW-1:0];
    dst_hit_d  = dst_hit_q;
    src_hit_d  = src_hit_q;
    free_hit_d = free_hit_q;
    dst_port_d = dst_port_q;
    src_idx_d  = src_idx_q;
    free_idx_d = free_idx_q;
    job_d      = job_q;
    res_d      = res_q;
    case (state_q)
      l2sd_pkg::BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = scan_q[IW-1:0];
        mem_wdata = '0;
        scan_d    = scan_q + (IW + 1)'(1);
      end
      l2sd_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop             = 1'b1;
          job_d             = q_job_i;
          scan_d            = '0;
          dst_hit_d         = 1'b0;
          src_hit_d         = 1'b0;
          free_hit_d        = 1'b0;
          res_d.action      = (q_job_i.kind == l2sd_pkg::JOB_FLUSH) ? l2sd_pkg::ACT_FLUSHED
                                                                    : q_job_i.action;
          res_d.egress_port = '0;
          res_d.learned     = 1'b0;
          res_d.table_full  = 1'b0;
        end
      end
      l2sd_pkg::BK_SCAN: begin
        if (scan_q != SCAN_END) begin
          mem_re    = 1'b1;
          chk_vld_d = 1'b1;
          scan_d    = scan_q + (IW + 1)'(1);
        end
        if (job_q.kind == l2sd_pkg::JOB_FLUSH) begin
          mem_we = flush_m;
        end
        // First hit wins, in index order.
        if (dst_m && !dst_hit_q) begin
          dst_hit_d  = 1'b1;
          dst_port_d = rd_data_q.port;
        end
        if (src_m && !src_hit_q) begin
          src_hit_d = 1'b1;
          src_idx_d = chk_idx_q;
        end
        if (free_m && !free_hit_q) begin
          free_hit_d = 1'b1;
          free_idx_d = chk_idx_q;
        end
      end
      l2sd_pkg::BK_DECIDE: begin
        if (dst_hit_q && dst_port_q == job_q.port) begin
          res_d.action = l2sd_pkg::ACT_SAME_PORT;
        end else begin
          res_d.action      = dst_hit_q ? l2sd_pkg::ACT_FORWARD : l2sd_pkg::ACT_FLOOD;
          res_d.egress_port = dst_hit_q ? dst_port_q : '0;
          if (src_hit_q || free_hit_q) begin
            mem_we          = 1'b1;
            mem_waddr       = src_hit_q ? src_idx_q : free_idx_q;
            mem_wdata.valid = 1'b1;
            mem_wdata.tag   = job_q.tag;
            mem_wdata.mac   = job_q.src;
            mem_wdata.port  = job_q.port;
            res_d.learned   = 1'b1;
          end else begin
            res_d.table_full = 1'b1;
          end
        end
      end
      l2sd_pkg::BK_EMIT: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
    out_valid_d = out_load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= l2sd_pkg::BK_CLEAR;
      scan_q      <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      dst_hit_q   <= 1'b0;
      src_hit_q   <= 1'b0;
      free_hit_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
      dst_hit_q   <= dst_hit_d;
      src_hit_q   <= src_hit_d;
      free_hit_q  <= free_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q  <= chk_idx_d;
    dst_port_q <= dst_port_d;
    src_idx_q  <= src_idx_d;
    free_idx_q <= free_idx_d;
    job_q      <= job_d;
    res_q      <= res_d;
    if (out_load) begin
      out_res_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  assign q_pop_o     = q_pop;
  assign clearing_o  = state_q == l2sd_pkg::BK_CLEAR;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  `L2SD_ASSERT_SAME(a_idle_no_write, state_q == l2sd_pkg::BK_IDLE, !mem_we, "table written while idle")
  `L2SD_ASSERT_SAME(a_learn_action, state_q == l2sd_pkg::BK_EMIT && res_q.learned, res_q.action == l2sd_pkg::ACT_FLOOD || res_q.action == l2sd_pkg::ACT_FORWARD, "learned on a non-learning action")
  `L2SD_ASSERT_SAME(a_learn_full_excl, state_q == l2sd_pkg::BK_EMIT, !(res_q.learned && res_q.table_full), "learned and table_full both set")
  `L2SD_ASSERT_NEXT(a_pop_starts_scan, q_pop && q_job_i.kind != l2sd_pkg::JOB_DONE, state_q == l2sd_pkg::BK_SCAN && scan_q == '0, "table request did not start a scan")

endmodule

>>> design/l2_learning_switch_decision.sv
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// in        in_valid_i / in_ready_o  in_req_i  (l2sd_pkg::in_req_t)
// out       out_valid_o / out_ready_i out_res_o (l2sd_pkg::out_res_t)
// cfg       cfg_we_i                 cfg_idx_i, cfg_data_i
//
// Accept to out_valid_o on an idle engine: packet requests pass through the table scan,
// the decide step and the emit step; flush requests skip the decide step (one table read
// port, one entry scanned per cycle). Bad-source and blocked requests skip the scan.
// After reset a clearing pass writes every table entry, one entry per cycle;
// in_ready_o is low until done.
// A two-entry queue sits between classification and the table engine; the result
// register lets the next request start while a result waits on out_ready_i.

module l2_learning_switch_decision #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [l2sd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [l2sd_pkg::MAC_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  l2sd_pkg::in_req_t              in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output l2sd_pkg::out_res_t             out_res_o
);

  l2sd_pkg::front_stat_t stat;
  l2sd_pkg::job_t        push_job;
  l2sd_pkg::job_t        head_job;
  logic                  push;
  logic                  pop;
  logic                  q_full;
  logic                  q_empty;
  logic                  clearing;

  assign stat.q_full   = q_full;
  assign stat.clearing = clearing;

  l2sd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .stat_i     (stat),
    .push_o     (push),
    .job_o      (push_job)
  );

  l2sd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .job_o   (head_job)
  );

  l2sd_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_job_i     (head_job),
    .q_pop_o     (pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import l2sd_pkg::*;

  localparam int FDB_DEPTH = 256;
  localparam int HOST_N = 24;

  localparam logic [MAC_W-1:0] MAC_NIL   = 48'h0000_0000_0000;
  localparam logic [MAC_W-1:0] MAC_TOP   = 48'hFEFF_FFFF_FFFF;  // highest unicast
  localparam logic [MAC_W-1:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;
  localparam logic [MAC_W-1:0] HOST_C    = 48'h02AA_0000_0001;
  localparam logic [MAC_W-1:0] HOST_D    = 48'h02AA_0000_0002;
  localparam logic [MAC_W-1:0] HOST_E    = 48'h02AA_0000_0003;

  localparam out_res_t RES_NONE        = '0;
  localparam out_res_t RES_FLUSHED     = '{ACT_FLUSHED, 8'd0, 1'b0, 1'b0};
  localparam out_res_t RES_BAD_SRC     = '{ACT_BAD_SRC, 8'd0, 1'b0, 1'b0};
  localparam out_res_t RES_BLOCK       = '{ACT_BLOCK, 8'd0, 1'b0, 1'b0};
  localparam out_res_t RES_FLOOD_LEARN = '{ACT_FLOOD, 8'd0, 1'b1, 1'b0};

  typedef struct {
    in_req_t  req;
    logic     has_res;
    out_res_t res;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [MAC_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_req_t              in_req_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_res_t             out_res_o;

  // predictor state: learned address table and block list
  logic              fdb_valid [FDB_DEPTH];
  logic [SW_W-1:0]   fdb_sw    [FDB_DEPTH];
  logic [VKEY_W-1:0] fdb_vkey  [FDB_DEPTH];
  logic [MAC_W-1:0]  fdb_mac   [FDB_DEPTH];
  logic [PORT_W-1:0] fdb_port  [FDB_DEPTH];
  logic [MAC_W-1:0]  blk_a = BLOCK_MAC_A_RST;
  logic [MAC_W-1:0]  blk_b = BLOCK_MAC_B_RST;

  logic [MAC_W-1:0] host_mac [HOST_N];
  dir_row_t         dir_rows [$];
  out_res_t         want_res [$];
  out_res_t         exp_r;

  int unsigned err_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned full_cnt = 0;
  int unsigned act_cnt [0:7];
  int unsigned burst_left = 0;
  int unsigned ready_run = 0;

  always #4 clk_i = ~clk_i;

  l2_learning_switch_decision #(
    .TABLE_DEPTH(FDB_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

  function automatic int fdb_lookup(logic [SW_W-1:0] sw, logic [VKEY_W-1:0] vkey,
                                    logic [MAC_W-1:0] mac);
    for (int i = 0; i < FDB_DEPTH; i++) begin
      if (fdb_valid[i] && fdb_sw[i] == sw && fdb_vkey[i] == vkey && fdb_mac[i] == mac)
        return i;
    end
    return -1;
  endfunction

  // Decision for one request; flood/forward learns the source, a flush clears its switch.
  function automatic out_res_t fdb_decide(in_req_t r);
    out_res_t          res;
    logic [VKEY_W-1:0] vkey;
    int                hit;
    int                slot;
    res = '0;
    if (r.command) begin
      for (int i = 0; i < FDB_DEPTH; i++) begin
        if (fdb_valid[i] && fdb_sw[i] == r.switch_id) fdb_valid[i] = 1'b0;
      end
      res.action = ACT_FLUSHED;
      return res;
    end
    if (r.src_mac[MCAST_BIT]) begin
      res.action = ACT_BAD_SRC;
      return res;
    end
    if (r.dst_mac == blk_a || r.dst_mac == blk_b) begin
      res.action = ACT_BLOCK;
      return res;
    end
    vkey = r.vlan_tagged ? {1'b0, r.vlan_id} : UNTAGGED_KEY;
    // destination lookup happens before the source is learned
    hit = r.dst_mac[MCAST_BIT] ? -1 : fdb_lookup(r.switch_id, vkey, r.dst_mac);
    if (hit < 0) begin
      res.action = ACT_FLOOD;
    end else if (fdb_port[hit] == r.in_port) begin
      res.action = ACT_SAME_PORT;
      return res;
    end else begin
      res.action = ACT_FORWARD;
      res.egress_port = fdb_port[hit];
    end
    slot = fdb_lookup(r.switch_id, vkey, r.src_mac);
    if (slot < 0) begin
      for (int i = 0; i < FDB_DEPTH; i++) begin
        if (!fdb_valid[i]) begin
          slot = i;
          break;
        end
      end
    end
    if (slot >= 0) begin
      fdb_valid[slot] = 1'b1;
      fdb_sw[slot] = r.switch_id;
      fdb_vkey[slot] = vkey;
      fdb_mac[slot] = r.src_mac;
      fdb_port[slot] = r.in_port;
      res.learned = 1'b1;
    end else begin
      res.table_full = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[MAC_W-1:0];
  endfunction

  function automatic in_req_t pkt(logic cmd, logic [SW_W-1:0] sw, logic [PORT_W-1:0] port,
                                  logic vtag, logic [VID_W-1:0] vid,
                                  logic [MAC_W-1:0] src, logic [MAC_W-1:0] dst);
    in_req_t r;
    r.command = cmd;
    r.switch_id = sw;
    r.in_port = port;
    r.src_mac = src;
    r.dst_mac = dst;
    r.vlan_tagged = vtag;
    r.vlan_id = vid;
    return r;
  endfunction

  // Mostly hosts from a small pool on a few switches, VLANs and ports so that
  // lookups hit; the rest is fully random noise and the odd flush.
  function automatic in_req_t make_traffic();
    in_req_t     r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r = pkt(1'b0, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
            1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)), rand_mac(), rand_mac());
    if (pick < 2) begin
      r.command = 1'b1;
    end else if (pick >= 14) begin
      r.switch_id = 4'($urandom_range(0, 3));
      if ($urandom_range(0, 3) != 0) r.in_port = 8'($urandom_range(0, 3));
      if (r.vlan_tagged)
        r.vlan_id = $urandom_range(0, 1) ? 12'hFFF : 12'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 92) r.src_mac = host_mac[$urandom_range(0, HOST_N - 1)];
      else if (pick < 96) r.src_mac = host_mac[$urandom_range(0, HOST_N - 1)] | (48'h1 << MCAST_BIT);
      pick = $urandom_range(0, 99);
      if (pick < 60) r.dst_mac = host_mac[$urandom_range(0, HOST_N - 1)];
      else if (pick < 64) r.dst_mac = blk_a;
      else if (pick < 68) r.dst_mac = blk_b;
      else if (pick < 72) r.dst_mac = MAC_BCAST;
      else if (pick < 78) r.dst_mac[MCAST_BIT] = 1'b1;
    end
    return r;
  endfunction

  // Sender: bursts of random length, gaps in between.
  task automatic push_req(input in_req_t r, input logic has_res, input out_res_t res);
    out_res_t pred;
    if (burst_left == 0) begin
      repeat (($urandom_range(0, 15) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 6))
        @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    pred = fdb_decide(r);
    want_res.push_back(has_res ? res : pred);
    do @(posedge clk_i); while (!in_ready_o);
    sent_cnt++;
    burst_left--;
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  // Hold off the sender until every outstanding request has its result.
  task automatic drain();
    if (burst_left != 0) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
    end
    while (want_res.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [MAC_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BLOCK_MAC_A) blk_a = val;
    else blk_b = val;
  endtask

  // Receiver: short and long stalls, some long stretches always ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (ready_run == 0) begin
        if (out_ready_i) begin
          out_ready_i <= 1'b0;
          ready_run = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 600)
                                                   : $urandom_range(1, 8);
        end else begin
          out_ready_i <= 1'b1;
          ready_run = ($urandom_range(0, 7) == 0) ? $urandom_range(500, 3000)
                                                  : $urandom_range(1, 60);
        end
      end else begin
        ready_run--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (want_res.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 20)
          $display("%0t: unexpected result: action %0d port %0d learned %0b full %0b",
                   $time, out_res_o.action, out_res_o.egress_port, out_res_o.learned,
                   out_res_o.table_full);
      end else begin
        exp_r = want_res.pop_front();
        if (out_res_o.action !== exp_r.action ||
            out_res_o.egress_port !== exp_r.egress_port ||
            out_res_o.learned !== exp_r.learned || out_res_o.table_full !== exp_r.table_full) begin
          err_cnt++;
          if (err_cnt <= 20)
            $display({"%0t: expected action %0d port %0d learned %0b full %0b,",
                      " got action %0d port %0d learned %0b full %0b"},
                     $time, exp_r.action, exp_r.egress_port, exp_r.learned, exp_r.table_full,
                     out_res_o.action, out_res_o.egress_port, out_res_o.learned,
                     out_res_o.table_full);
        end
      end
      act_cnt[out_res_o.action]++;
      if (out_res_o.table_full) full_cnt++;
    end
  end

  initial begin
    #100_000_000;
    $display("l2_learning_switch_decision: mismatch");
    $finish;
  end

  initial begin
    in_req_t     r;
    logic [15:0] fidx;
    foreach (fdb_valid[i]) fdb_valid[i] = 1'b0;
    foreach (act_cnt[i]) act_cnt[i] = 0;
    foreach (host_mac[i]) begin
      host_mac[i] = rand_mac();
      host_mac[i][MCAST_BIT] = 1'b0;
    end
    host_mac[0] = MAC_NIL;
    host_mac[1] = MAC_TOP;

    // directed rows, reset block list
    dir_rows.push_back(dir_row_t'{pkt(1'b1, 4'd0, 8'd0, 1'b0, 12'd0, MAC_NIL, MAC_NIL),
                                  1'b1, RES_FLUSHED});
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd0, 8'd0, 1'b0, 12'd0, 48'h0100_0000_0000,
                                      MAC_NIL), 1'b1, RES_BAD_SRC});
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd15, 8'd255, 1'b1, 12'hFFF, MAC_BCAST,
                                      MAC_BCAST), 1'b1, RES_BAD_SRC});
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd1, 8'd1, 1'b0, 12'd0, HOST_C, BLOCK_MAC_A_RST),
                                  1'b1, RES_BLOCK});
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd1, 8'd1, 1'b1, 12'd7, HOST_C, BLOCK_MAC_B_RST),
                                  1'b1, RES_BLOCK});
    // bad source wins over a blocked destination
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd0, 8'd0, 1'b0, 12'd0, 48'h0300_0000_0000,
                                      BLOCK_MAC_A_RST), 1'b1, RES_BAD_SRC});
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd0, 8'd0, 1'b0, 12'd0, MAC_NIL, MAC_BCAST),
                                  1'b1, RES_FLOOD_LEARN});
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd15, 8'd255, 1'b1, 12'hFFF, MAC_TOP, MAC_NIL),
                                  1'b1, RES_FLOOD_LEARN});
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd0, 8'd7, 1'b0, 12'd0, HOST_C, MAC_NIL),
                                  1'b0, RES_NONE});
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd0, 8'd0, 1'b0, 12'hABC, HOST_C, MAC_NIL),
                                  1'b0, RES_NONE});
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd0, 8'd4, 1'b1, 12'h000, HOST_D, MAC_NIL),
                                  1'b0, RES_NONE});
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd15, 8'd0, 1'b1, 12'hFFF, HOST_E, MAC_TOP),
                                  1'b0, RES_NONE});
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd0, 8'd9, 1'b0, 12'd0, HOST_C, MAC_NIL),
                                  1'b0, RES_NONE});
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd0, 8'd3, 1'b0, 12'd0, MAC_NIL, HOST_C),
                                  1'b0, RES_NONE});
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd0, 8'd1, 1'b0, 12'd0, HOST_D,
                                      48'h0100_5E00_0001), 1'b0, RES_NONE});
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd0, 8'd9, 1'b0, 12'hFFF, MAC_NIL, HOST_C),
                                  1'b0, RES_NONE});
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd1, 8'd2, 1'b0, 12'd0, HOST_D, MAC_NIL),
                                  1'b0, RES_NONE});
    dir_rows.push_back(dir_row_t'{pkt(1'b1, 4'd15, 8'd0, 1'b0, 12'd0, MAC_NIL, MAC_NIL),
                                  1'b1, RES_FLUSHED});
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd15, 8'd1, 1'b1, 12'hFFF, HOST_D, MAC_TOP),
                                  1'b0, RES_NONE});
    dir_rows.push_back(dir_row_t'{pkt(1'b1, 4'd3, 8'd0, 1'b0, 12'd0, MAC_NIL, MAC_NIL),
                                  1'b1, RES_FLUSHED});
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd0, 8'd8, 1'b0, 12'd0, HOST_E, HOST_C),
                                  1'b0, RES_NONE});
    dir_rows.push_back(dir_row_t'{pkt(1'b0, 4'd2, 8'd5, 1'b0, 12'd0, HOST_E,
                                      48'h0180_C200_0001), 1'b0, RES_NONE});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) push_req(dir_rows[i].req, dir_rows[i].has_res, dir_rows[i].res);
    drain();

    // block list at the extremes
    write_cfg(CFG_BLOCK_MAC_A, MAC_NIL);
    write_cfg(CFG_BLOCK_MAC_B, MAC_BCAST);
    repeat (500) push_req(make_traffic(), 1'b0, RES_NONE);
    drain();

    // block a pool host; then overfill the table from one switch
    write_cfg(CFG_BLOCK_MAC_A, host_mac[2]);
    write_cfg(CFG_BLOCK_MAC_B, rand_mac());
    for (int i = 0; i < 300; i++) begin
      fidx = 16'(i);
      r = pkt(1'b0, 4'd5, 8'(i), 1'b1, 12'd9, {16'h0600, 16'h0000, fidx}, MAC_BCAST);
      if (i % 3 == 2) r.dst_mac = {16'h0600, 16'h0000, fidx - 16'd2};
      push_req(r, 1'b0, RES_NONE);
    end
    repeat (200) push_req(make_traffic(), 1'b0, RES_NONE);
    push_req(pkt(1'b1, 4'd5, 8'd0, 1'b0, 12'd0, MAC_NIL, MAC_NIL), 1'b1, RES_FLUSHED);
    repeat (250) push_req(make_traffic(), 1'b0, RES_NONE);
    drain();

    write_cfg(CFG_BLOCK_MAC_A, BLOCK_MAC_A_RST);
    write_cfg(CFG_BLOCK_MAC_B, BLOCK_MAC_B_RST);
    repeat (500) push_req(make_traffic(), 1'b0, RES_NONE);
    drain();
    repeat (FDB_DEPTH + 40) @(posedge clk_i);

    $display("%0d requests under three block lists: %0d flood, %0d forward, %0d same-port drop,",
             sent_cnt, act_cnt[ACT_FLOOD], act_cnt[ACT_FORWARD], act_cnt[ACT_SAME_PORT]);
    $display("%0d blocked, %0d bad source, %0d flush, %0d with the table full",
             act_cnt[ACT_BLOCK], act_cnt[ACT_BAD_SRC], act_cnt[ACT_FLUSHED], full_cnt);
    if (err_cnt == 0 && want_res.size() == 0) begin
      $display("l2_learning_switch_decision: match");
    end else begin
      $display("l2_learning_switch_decision: mismatch");
    end
    $finish;
  end

endmodule
